@@ rtl/core/rsi_pkg.sv @@
// Shared types and constants for the ray/sphere intersection block.
// Used by rsi_front, rsi_sqrt_cell and ray_sphere_intersect.
package rsi_pkg;

  localparam int PosW   = 32;              // Q20.12 position
  localparam int DirW   = 16;              // Q1.14 direction
  localparam int RadW   = 31;              // unsigned Q19.12 radius
  localparam int OpW    = PosW + 1;        // center minus origin
  localparam int ProdW  = OpW + DirW;      // one term of op.dir, Q.26
  localparam int DotW   = ProdW + 2;       // sum of three terms
  localparam int BW     = DotW - 14;       // b in Q.12, signed
  localparam int BMagW  = BW;              // |b|
  localparam int BLoW   = 18;              // low split of |b|
  localparam int BHiW   = BMagW - BLoW;    // high split of |b|
  localparam int SqW    = 2 * PosW;        // one op square
  localparam int NegW   = SqW + 2;         // op.op
  localparam int R2W    = 2 * RadW;        // r*r
  localparam int RemW   = 77;              // discriminant / remainder, signed
  localparam int RootW  = 38;              // floor(sqrt) bits
  localparam int TW     = RootW + 2;       // b +/- s
  localparam int RoundBias = 8192;         // half of 2^14

  typedef struct packed {
    logic                    valid;
    logic                    miss;
    logic signed [BW-1:0]    b;
    logic [RemW-1:0]         rem;
    logic [RootW-1:0]        root;
  } sq_t;

endpackage

@@ rtl/core/rsi_front.sv @@
// Front pipeline: op, dot product, rounding, squares and discriminant.
// Depends on rsi_pkg; feeds the square root chain of rsi_sqrt_cell.
module rsi_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [31:0]          origin_x,
  input  logic signed [31:0]          origin_y,
  input  logic signed [31:0]          origin_z,
  input  logic signed [15:0]          dir_x,
  input  logic signed [15:0]          dir_y,
  input  logic signed [15:0]          dir_z,
  input  logic signed [31:0]          center_x,
  input  logic signed [31:0]          center_y,
  input  logic signed [31:0]          center_z,
  input  logic [30:0]                 sphere_radius,
  output rsi_pkg::sq_t                out
);
  import rsi_pkg::*;

  logic [5:0] v;

  // stage 1
  logic signed [OpW-1:0]  op_x, op_y, op_z;
  logic signed [DirW-1:0] d_x, d_y, d_z;
  logic [RadW-1:0]        rad1;
  // stage 2
  logic signed [ProdW-1:0] p_x, p_y, p_z;
  logic [SqW-1:0]          q_x, q_y, q_z;
  logic [R2W-1:0]          r2_2;
  // stage 3
  logic signed [BW-1:0]    b3;
  logic [NegW-1:0]         neg3;
  logic [R2W-1:0]          r2_3;
  // stage 4
  logic signed [BW-1:0]    b4;
  logic [NegW-1:0]         neg4;
  logic [R2W-1:0]          r2_4;
  logic [2*BHiW-1:0]       hh4;
  logic [BHiW+BLoW-1:0]    hl4;
  logic [2*BLoW-1:0]       ll4;
  // stage 5
  logic signed [BW-1:0]    b5;
  logic [NegW-1:0]         neg5;
  logic [RemW-1:0]         pos5;

  logic [OpW-2:0]          m_x, m_y, m_z;
  logic signed [DotW-1:0]  dot;
  logic [BMagW-1:0]        bm;

  always_comb begin
    m_x = (op_x < 0) ? (OpW-1)'(-op_x) : (OpW-1)'(op_x);
    m_y = (op_y < 0) ? (OpW-1)'(-op_y) : (OpW-1)'(op_y);
    m_z = (op_z < 0) ? (OpW-1)'(-op_z) : (OpW-1)'(op_z);
    dot = DotW'(p_x) + DotW'(p_y) + DotW'(p_z) + DotW'(RoundBias);
    bm  = (b3 < 0) ? BMagW'(-b3) : BMagW'(b3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    // stage 1: relative center
    op_x <= OpW'(center_x) - OpW'(origin_x);
    op_y <= OpW'(center_y) - OpW'(origin_y);
    op_z <= OpW'(center_z) - OpW'(origin_z);
    d_x  <= dir_x;
    d_y  <= dir_y;
    d_z  <= dir_z;
    rad1 <= sphere_radius;
    // stage 2: products and squares
    p_x  <= ProdW'(op_x) * ProdW'(d_x);
    p_y  <= ProdW'(op_y) * ProdW'(d_y);
    p_z  <= ProdW'(op_z) * ProdW'(d_z);
    q_x  <= SqW'(m_x) * SqW'(m_x);
    q_y  <= SqW'(m_y) * SqW'(m_y);
    q_z  <= SqW'(m_z) * SqW'(m_z);
    r2_2 <= R2W'(rad1) * R2W'(rad1);
    // stage 3: round b (floor after bias), sum op squares
    b3   <= dot[DotW-1:14];
    neg3 <= NegW'(q_x) + NegW'(q_y) + NegW'(q_z);
    r2_3 <= r2_2;
    // stage 4: partial products of |b|^2
    b4   <= b3;
    neg4 <= neg3;
    r2_4 <= r2_3;
    hh4  <= (2*BHiW)'(bm[BMagW-1:BLoW]) * (2*BHiW)'(bm[BMagW-1:BLoW]);
    hl4  <= (BHiW+BLoW)'(bm[BMagW-1:BLoW]) * (BHiW+BLoW)'(bm[BLoW-1:0]);
    ll4  <= (2*BLoW)'(bm[BLoW-1:0]) * (2*BLoW)'(bm[BLoW-1:0]);
    // stage 5: b^2 + r^2
    b5   <= b4;
    neg5 <= neg4;
    pos5 <= (RemW'(hh4) << (2*BLoW)) + (RemW'(hl4) << (BLoW+1)) + RemW'(ll4)
            + RemW'(r2_4);
    // stage 6: discriminant
    out.b    <= b5;
    out.rem  <= pos5 - RemW'(neg5);
    out.miss <= pos5 < RemW'(neg5);
    out.root <= '0;
  end

  assign out.valid = v[5];

endmodule

@@ rtl/core/rsi_sqrt_cell.sv @@
// One cell of the square root chain: settles one root bit per cell.
// Depends on rsi_pkg.
module rsi_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  rsi_pkg::sq_t  in,
  output rsi_pkg::sq_t  out
);
  import rsi_pkg::*;

  logic [RemW-1:0] trial;
  logic            take;

  // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k)
  always_comb begin
    trial = (RemW'(in.root) << (BIT + 1)) | (RemW'(1) << (2 * BIT));
    take  = in.rem >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else begin
      out.valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    out.miss <= in.miss;
    out.b    <= in.b;
    if (take) begin
      out.rem  <= in.rem - trial;
      out.root <= in.root | (RootW'(1) << BIT);
    end else begin
      out.rem  <= in.rem;
      out.root <= in.root;
    end
  end

endmodule

@@ rtl/core/ray_sphere_intersect.sv @@
// Top level of the ray/sphere intersection block.
// Depends on rsi_pkg, rsi_front and rsi_sqrt_cell.
//
//  channel   handshake        payload
//  -------   ---------------  ---------------------------------------------
//  input     start / busy     origin_*, dir_*, center_*, sphere_radius
//  result    done (strobe)    miss, distance
//
// One test is accepted every cycle; busy stays low.
// The pipeline holds six front stages, one cell per root bit (38), and
// the output register. The square root chain sets the length.
// Reset clears the valid bits of every stage; payload is not reset.
// The receiver cannot stall: each result shows for one cycle with done.
module ray_sphere_intersect (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  origin_x,
  input  logic signed [31:0]  origin_y,
  input  logic signed [31:0]  origin_z,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  input  logic signed [31:0]  center_x,
  input  logic signed [31:0]  center_y,
  input  logic signed [31:0]  center_z,
  input  logic [30:0]         sphere_radius,
  output logic                done,
  output logic                miss,
  output logic signed [31:0]  distance
);
  import rsi_pkg::*;

  localparam int Latency = 6 + RootW + 1;

  sq_t chain [RootW+1];

  logic signed [TW-1:0] t_lo, t_hi, dist_sel;

  // never hold off a transfer
  assign busy = 1'b0;

  rsi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (start),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .origin_z      (origin_z),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius),
    .out           (chain[0])
  );

  // one cell per root bit, most significant first
  for (genvar g = 0; g < RootW; g++) begin : g_cell
    rsi_sqrt_cell #(
      .BIT (RootW - 1 - g)
    ) u_cell (
      .clk (clk),
      .rst (rst),
      .in  (chain[g]),
      .out (chain[g+1])
    );
  end

  // pick the nearer positive root, else the far one, then saturate
  always_comb begin
    t_lo = TW'(chain[RootW].b) - TW'({1'b0, chain[RootW].root});
    t_hi = TW'(chain[RootW].b) + TW'({1'b0, chain[RootW].root});
    dist_sel = (t_lo > 0) ? t_lo : t_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain[RootW].valid;
    end
  end

  always_ff @(posedge clk) begin
    miss <= chain[RootW].miss;
    priority if (chain[RootW].miss) begin
      distance <= '0;
    end else if (dist_sel > TW'(32'sh7FFF_FFFF)) begin
      distance <= 32'sh7FFF_FFFF;
    end else if (dist_sel < -TW'(33'sh0_8000_0000)) begin
      distance <= 32'sh8000_0000;
    end else begin
      distance <= dist_sel[31:0];
    end
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##Latency done) else $error("result strobe missing");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && miss |-> distance == 0) else $error("miss with nonzero distance");
  a_miss_sign: assert property (@(posedge clk) disable iff (rst)
    chain[0].valid |-> chain[0].miss == chain[0].rem[RemW-1])
    else $error("miss flag disagrees with discriminant sign");
`endif

endmodule
